/* hw/rtl/upscl_pkg.sv */
package upscl_pkg;

    // limits of the image geometry
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_ROWS  = 4096;
    localparam int MAX_SCALE = 100;

    // configuration register widths and indexes
    localparam int SCALE_W  = 7;
    localparam int RWIDTH_W = 11;
    localparam int RCOUNT_W = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd2;

    // counter widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int REP_W = $clog2(MAX_SCALE);
    localparam int ROW_W = $clog2(MAX_ROWS);

    localparam int PIX_W = 24;

    // input action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

    // result kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOADED  = 2'd0;
    localparam t_kind KIND_PIXEL   = 2'd1;
    localparam t_kind KIND_REFUSED = 2'd2;
    localparam t_kind KIND_IDLE    = 2'd3;

endpackage

/* hw/rtl/integer_pixel_upscaler_top.sv */
// Nearest-neighbor integer upscaler for 24-bit pixels. Configure scale (1..100), row_width
// (1..1024) and row_count (1..4096) while the block is idle; out-of-range values are clamped
// (zero acts as one). Send one input row as load items (tuser 0), then emit ticks (tuser 1):
// each tick returns one output pixel, every stored pixel repeated scale times across and the
// row repeated scale times down. The last pixel of an output row has tlast set and carries the
// number of zero bytes that pad the output row to a multiple of four bytes; the last pixel of
// the image also sets the frame-end flag. A load during emission comes back as refused, and an
// emit tick with no row ready comes back as idle. Every input item gives exactly one result
// item. The block takes one item per clock: the line buffer is a single-port 1024 x 24 memory
// with a registered read, and the result sits in one output register, so an item is accepted
// whenever the output register is empty or being drained in the same cycle. The result
// is registered and shows on the master side in the cycle after acceptance.
module integer_pixel_upscaler_top
    import upscl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,

    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
    input  logic                 s_axis_tuser,   // action

    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // blue_out, green_out, red_out, pad_bytes, zeros
    output logic                 m_axis_tlast,   // row_end
    output logic [2:0]           m_axis_tuser    // kind[1:0], frame_end[2]
);

    // configuration registers
    logic [SCALE_W-1:0]  r_scale;
    logic [RWIDTH_W-1:0] r_row_width;
    logic [RCOUNT_W-1:0] r_row_count;

    // effective (clamped) geometry
    logic [SCALE_W-1:0]  eff_scale;
    logic [RWIDTH_W-1:0] eff_width;
    logic [RCOUNT_W-1:0] eff_rows;

    // sequencing state
    logic [COL_W-1:0] r_load_col,  n_load_col;
    logic             r_row_ready, n_row_ready;
    logic [COL_W-1:0] r_emit_col,  n_emit_col;
    logic [REP_W-1:0] r_across,    n_across;
    logic [REP_W-1:0] r_down,      n_down;
    logic [ROW_W-1:0] r_rows_done, n_rows_done;

    // result register
    logic             r_out_valid;
    t_kind            r_kind,      n_kind;
    logic [1:0]       r_pad,       n_pad;
    logic             r_row_end,   n_row_end;
    logic             r_frame_end, n_frame_end;
    logic [PIX_W-1:0] r_rd_data;

    // line buffer
    logic [PIX_W-1:0] r_line_mem [MAX_WIDTH];

    logic             accept;
    logic             do_load;
    logic             do_emit;
    logic [COL_W:0]   load_col_inc;
    logic [COL_W:0]   emit_col_inc;
    logic [REP_W:0]   across_inc;
    logic [REP_W:0]   down_inc;
    logic [ROW_W:0]   rows_inc;
    logic [3:0]       pad_prod;
    logic [PIX_W-1:0] pix_out;

    // ready whenever the output register is free this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign do_load       = accept && (s_axis_tuser == ACT_LOAD) && !r_row_ready;
    assign do_emit       = accept && (s_axis_tuser == ACT_EMIT) && r_row_ready;

    // clamp the registers into their legal ranges
    always_comb begin
        if (r_scale == '0) begin
            eff_scale = SCALE_W'(1);
        end else if (r_scale > SCALE_W'(MAX_SCALE)) begin
            eff_scale = SCALE_W'(MAX_SCALE);
        end else begin
            eff_scale = r_scale;
        end
        if (r_row_width == '0) begin
            eff_width = RWIDTH_W'(1);
        end else if (r_row_width > RWIDTH_W'(MAX_WIDTH)) begin
            eff_width = RWIDTH_W'(MAX_WIDTH);
        end else begin
            eff_width = r_row_width;
        end
        if (r_row_count == '0) begin
            eff_rows = RCOUNT_W'(1);
        end else if (r_row_count > RCOUNT_W'(MAX_ROWS)) begin
            eff_rows = RCOUNT_W'(MAX_ROWS);
        end else begin
            eff_rows = r_row_count;
        end
    end

    assign load_col_inc = {1'b0, r_load_col} + 1'b1;
    assign emit_col_inc = {1'b0, r_emit_col} + 1'b1;
    assign across_inc   = {1'b0, r_across} + 1'b1;
    assign down_inc     = {1'b0, r_down} + 1'b1;
    assign rows_inc     = {1'b0, r_rows_done} + 1'b1;

    // pad = -(3 * w * s) mod 4, which reduces to (w * s) mod 4
    assign pad_prod = eff_width[1:0] * eff_scale[1:0];

    // next state and result fields
    always_comb begin
        n_load_col  = r_load_col;
        n_row_ready = r_row_ready;
        n_emit_col  = r_emit_col;
        n_across    = r_across;
        n_down      = r_down;
        n_rows_done = r_rows_done;
        n_kind      = KIND_IDLE;
        n_pad       = 2'd0;
        n_row_end   = 1'b0;
        n_frame_end = 1'b0;

        if (s_axis_tuser == ACT_LOAD) begin
            if (r_row_ready) begin
                n_kind = KIND_REFUSED;
            end else begin
                n_kind = KIND_LOADED;
                if (load_col_inc >= eff_width) begin
                    n_load_col  = '0;
                    n_row_ready = 1'b1;
                    n_emit_col  = '0;
                    n_across    = '0;
                    n_down      = '0;
                end else begin
                    n_load_col = load_col_inc[COL_W-1:0];
                end
            end
        end else if (r_row_ready) begin
            n_kind   = KIND_PIXEL;
            n_across = across_inc[REP_W-1:0];
            if (across_inc >= {{(REP_W+1-SCALE_W){1'b0}}, eff_scale}) begin
                // pixel fully repeated across, move to the next column
                n_across   = '0;
                n_emit_col = emit_col_inc[COL_W-1:0];
                if (emit_col_inc >= eff_width) begin
                    // end of an output row
                    n_emit_col = '0;
                    n_pad      = pad_prod[1:0];
                    n_row_end  = 1'b1;
                    n_down     = down_inc[REP_W-1:0];
                    if (down_inc >= {{(REP_W+1-SCALE_W){1'b0}}, eff_scale}) begin
                        // input row fully repeated down, free the buffer
                        n_down      = '0;
                        n_row_ready = 1'b0;
                        n_rows_done = rows_inc[ROW_W-1:0];
                        if (rows_inc >= eff_rows) begin
                            n_rows_done = '0;
                            n_frame_end = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_W'(1);
            r_row_width <= RWIDTH_W'(1);
            r_row_count <= RCOUNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE:     r_scale     <= i_cfg_data[SCALE_W-1:0];
                CFG_ROW_WIDTH: r_row_width <= i_cfg_data[RWIDTH_W-1:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data[RCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col  <= '0;
            r_row_ready <= 1'b0;
            r_emit_col  <= '0;
            r_across    <= '0;
            r_down      <= '0;
            r_rows_done <= '0;
        end else if (accept) begin
            r_load_col  <= n_load_col;
            r_row_ready <= n_row_ready;
            r_emit_col  <= n_emit_col;
            r_across    <= n_across;
            r_down      <= n_down;
            r_rows_done <= n_rows_done;
        end
    end

    // line buffer: write on load, registered read on emit
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_line_mem[r_load_col] <= s_axis_tdata;
        end
        if (do_emit) begin
            r_rd_data <= r_line_mem[r_emit_col];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind      <= n_kind;
            r_pad       <= n_pad;
            r_row_end   <= n_row_end;
            r_frame_end <= n_frame_end;
        end
    end

    // color fields are zero on anything but a pixel
    assign pix_out = (r_kind == KIND_PIXEL) ? r_rd_data : '0;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_pad, pix_out};
    assign m_axis_tlast  = r_row_end;
    assign m_axis_tuser  = {r_frame_end, r_kind};

endmodule

/* tb/tb_integer_pixel_upscaler_top.sv */
module tb_integer_pixel_upscaler_top;
    import upscl_pkg::*;

    // quiet cycles (nothing accepted on either side) before the run is called hung
    localparam int unsigned HANG_LIMIT   = 2000;
    // input items for the random frame phase
    localparam int unsigned RANDOM_ITEMS = 200;
    // a random frame is cut off after this many items and the next one starts
    localparam int unsigned FRAME_CAP    = 800;
    // only the first mismatches get printed, the rest are counted
    localparam int unsigned PRINT_CAP    = 40;

    // one expected result item, field for field
    typedef struct packed {
        t_kind      kind;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [1:0] pad;
        logic       row_end;
        logic       frame_end;
    } t_upscale_px;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = CFG_SCALE;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata  = '0;   // blue_in[7:0], green_in[15:8], red_in[23:16]
    logic                 s_axis_tuser  = ACT_LOAD;   // action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;   // blue[7:0], green[15:8], red[23:16], pad_bytes[25:24]
    logic                 m_axis_tlast;   // row_end
    logic [2:0]           m_axis_tuser;   // kind[1:0], frame_end[2]

    integer_pixel_upscaler_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // upscaler image of the block: register copies and line state
    // ---------------------------------------------------------------
    int unsigned cfg_scale = 1;
    int unsigned cfg_width = 1;
    int unsigned cfg_rows  = 1;

    logic [23:0] row_pixels [MAX_WIDTH];
    int unsigned fill_col      = 0;   // next line buffer slot to load
    bit          row_full      = 1'b0;   // row loaded, emission under way
    int unsigned out_col       = 0;
    int unsigned across_n      = 0;
    int unsigned down_n        = 0;
    int unsigned rows_out      = 0;
    int unsigned written_depth = 0;   // slots 0 .. written_depth-1 hold a loaded pixel
    bit          frame_seen    = 1'b0;   // set when a frame end is predicted

    t_upscale_px results_due [$];

    // bookkeeping
    int unsigned mismatches      = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned pixels_out      = 0;
    int unsigned frames_done     = 0;
    int unsigned burst_left      = 0;
    int unsigned quiet_cycles    = 0;
    int unsigned rx_cycle        = 0;

    function automatic int unsigned clamp_limit(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // advance the line state by one accepted item and return its result
    function automatic t_upscale_px upscale_next(input logic act, input logic [23:0] pix);
        t_upscale_px r;
        int unsigned s;
        int unsigned w;
        int unsigned h;
        r = '0;
        s = clamp_limit(cfg_scale, MAX_SCALE);
        w = clamp_limit(cfg_width, MAX_WIDTH);
        h = clamp_limit(cfg_rows, MAX_ROWS);
        if (act == ACT_LOAD) begin
            if (row_full) begin
                r.kind = KIND_REFUSED;
            end else begin
                row_pixels[fill_col] = pix;
                if (fill_col >= written_depth)
                    written_depth = fill_col + 1;
                fill_col++;
                // "reached or passed": a narrower width set mid-load ends the row here
                if (fill_col >= w) begin
                    fill_col = 0;
                    row_full = 1'b1;
                    out_col  = 0;
                    across_n = 0;
                    down_n   = 0;
                end
                r.kind = KIND_LOADED;
            end
        end else if (!row_full) begin
            r.kind = KIND_IDLE;
        end else begin
            r.kind = KIND_PIXEL;
            {r.red, r.green, r.blue} = row_pixels[out_col];
            across_n++;
            if (across_n >= s) begin
                across_n = 0;
                out_col++;
                if (out_col >= w) begin
                    out_col   = 0;
                    r.pad     = 2'((4 - (w * s * 3) % 4) % 4);
                    r.row_end = 1'b1;
                    down_n++;
                    if (down_n >= s) begin
                        down_n   = 0;
                        row_full = 1'b0;
                        rows_out++;
                        if (rows_out >= h) begin
                            rows_out    = 0;
                            r.frame_end = 1'b1;
                            frame_seen  = 1'b1;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    // ---------------------------------------------------------------
    // result side: handshakes are judged at the falling edge, where
    // everything driven at the rising edge has settled
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        t_upscale_px want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $display("%0t: result with nothing expected, expected none, got kind %0d",
                             $time, m_axis_tuser[1:0]);
            end else begin
                want = results_due.pop_front();
                results_checked++;
                if (want.kind == KIND_PIXEL)
                    pixels_out++;
                if (want.frame_end)
                    frames_done++;
                check_field("kind",      want.kind,      m_axis_tuser[1:0]);
                check_field("blue",      want.blue,      m_axis_tdata[7:0]);
                check_field("green",     want.green,     m_axis_tdata[15:8]);
                check_field("red",       want.red,       m_axis_tdata[23:16]);
                check_field("pad_bytes", want.pad,       m_axis_tdata[25:24]);
                check_field("row_end",   want.row_end,   m_axis_tlast);
                check_field("frame_end", want.frame_end, m_axis_tuser[2]);
            end
        end
    end

    // receiver stall pattern: always ready, coin flip, short regular
    // stalls, then long stalls, taking turns in that order
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 256) % 4)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (rx_cycle % 4) != 0;
            default: m_axis_tready <= (rx_cycle % 64) >= 12;
        endcase
    end

    // hang detection: too long without any item moving on either side
    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, HANG_LIMIT, results_due.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // offer one item in bursts with random gaps; returns at the edge that takes it
    task automatic send_item(input logic act, input logic [23:0] pix);
        bit          took;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= act;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = s_axis_tready;
            if (took) begin
                results_due.push_back(upscale_next(act, pix));
                items_sent++;
            end
            @(posedge i_clk);
        end
    endtask

    // drop valid and wait until every result is back and the pipe is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SCALE:     cfg_scale = val % (1 << SCALE_W);
            CFG_ROW_WIDTH: cfg_width = val % (1 << RWIDTH_W);
            CFG_ROW_COUNT: cfg_rows  = val % (1 << RCOUNT_W);
            default:       ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned scl, input int unsigned wid,
                                input int unsigned rows);
        write_reg(CFG_SCALE, scl);
        write_reg(CFG_ROW_WIDTH, wid);
        write_reg(CFG_ROW_COUNT, rows);
    endtask

    // emit ticks until the current row has gone out scale times
    task automatic emit_rest();
        while (row_full)
            send_item(ACT_EMIT, 24'($urandom));
    endtask

    // raw scale, sometimes zero, mostly small to keep frames short
    function automatic int unsigned pick_scale();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 0;
        if (r == 1)
            return $urandom_range(4, 6);
        return $urandom_range(1, 3);
    endfunction

    // raw width; while a row is out, never wider than what the buffer holds
    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (row_full)
            return $urandom_range(0, (written_depth < 16) ? written_depth : 16);
        if (r == 0)
            return 0;
        if (r < 3)
            return $urandom_range(13, 40);
        return $urandom_range(1, 12);
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // emit ticks with no row report idle; reset geometry is 1x1, one row
    task automatic test_idle_and_defaults();
        send_item(ACT_EMIT, 24'hFFFFFF);
        send_item(ACT_EMIT, 24'h000000);
        send_item(ACT_LOAD, 24'h000000);
        send_item(ACT_EMIT, 24'hFFFFFF);   // row end, frame end, one pad byte
        send_item(ACT_EMIT, 24'h000000);   // idle again after the frame
    endtask

    // a load while the row is going out is refused and changes nothing
    task automatic test_refused_load();
        set_geometry(2, 2, 1);
        send_item(ACT_LOAD, 24'hFFFFFF);
        send_item(ACT_LOAD, 24'h000000);
        send_item(ACT_EMIT, 24'h0);
        send_item(ACT_EMIT, 24'h0);
        send_item(ACT_EMIT, 24'h0);
        send_item(ACT_LOAD, 24'h5A3C96);
        emit_rest();
    endtask

    // zero in every register acts as one
    task automatic test_register_clamps();
        set_geometry(0, 0, 0);
        send_item(ACT_LOAD, 24'hA5C3E7);
        send_item(ACT_EMIT, 24'h0);
    endtask

    // registers lowered below running counters end the run at the next step
    task automatic test_midrow_changes();
        set_geometry(3, 4, 3);
        repeat (4) send_item(ACT_LOAD, 24'($urandom));
        repeat (4) send_item(ACT_EMIT, 24'h0);
        write_reg(CFG_SCALE, 1);        // across count already past the new scale
        repeat (2) send_item(ACT_EMIT, 24'h0);
        write_reg(CFG_ROW_WIDTH, 2);    // column already past the new width
        emit_rest();
        write_reg(CFG_ROW_WIDTH, 5);
        repeat (3) send_item(ACT_LOAD, 24'($urandom));
        write_reg(CFG_ROW_WIDTH, 2);    // load column past the new width
        send_item(ACT_LOAD, 24'($urandom));
        write_reg(CFG_ROW_COUNT, 1);    // rows done already past the new count
        emit_rest();
    endtask

    // widest register value clamps to the full line buffer; the row is
    // cut short once a few pixels have gone out
    task automatic test_full_width_row();
        set_geometry(1, 2047, 1);
        while (!row_full)
            send_item(ACT_LOAD, 24'($urandom));
        repeat (8) send_item(ACT_EMIT, 24'h0);
        write_reg(CFG_ROW_WIDTH, 2);    // column already past the new width
        emit_rest();
    endtask

    // largest scale register value clamps to the largest scale across
    task automatic test_max_scale_row();
        set_geometry(127, 2, 1);
        repeat (2) send_item(ACT_LOAD, 24'($urandom));
        // first pixel repeated the full scale, then the second one starts
        repeat (MAX_SCALE + 1) send_item(ACT_EMIT, 24'h0);
        write_reg(CFG_SCALE, 1);        // across count already past the new scale
        emit_rest();
    endtask

    // largest row count register value does not end the frame early
    task automatic test_max_rows_frame();
        set_geometry(1, 1, 8191);
        frame_seen = 1'b0;
        repeat (24) begin
            send_item(ACT_LOAD, 24'($urandom));
            send_item(ACT_EMIT, 24'h0);
        end
        write_reg(CFG_ROW_COUNT, 1);    // rows done already past the new count
        send_item(ACT_LOAD, 24'($urandom));
        send_item(ACT_EMIT, 24'h0);
    endtask

    // whole frames of random geometry and content, with stray loads and
    // ticks mixed in and now and then a register rewritten mid-frame
    task automatic test_random_frames();
        int unsigned                start;
        int unsigned                n;
        int unsigned                cut_at;
        bit                         stray;
        logic [CFG_IDX_W-1:0]       cfg_idx;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            set_geometry(pick_scale(), pick_width(), $urandom_range(0, 3));
            frame_seen = 1'b0;
            n = 0;
            cut_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 60) : 0;
            while (!frame_seen && n < FRAME_CAP && items_sent - start < RANDOM_ITEMS) begin
                if (cut_at != 0 && n == cut_at) begin
                    cfg_idx = CFG_IDX_W'($urandom_range(CFG_SCALE, CFG_ROW_COUNT));
                    case (cfg_idx)
                        CFG_SCALE:     write_reg(CFG_SCALE, pick_scale());
                        CFG_ROW_WIDTH: write_reg(CFG_ROW_WIDTH, pick_width());
                        default:       write_reg(CFG_ROW_COUNT, $urandom_range(0, 3));
                    endcase
                end
                // mostly the item the block wants next, sometimes the other one
                stray = ($urandom_range(0, 19) == 0);
                send_item((row_full != stray) ? ACT_EMIT : ACT_LOAD, 24'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_defaults();
        test_refused_load();
        test_register_clamps();
        test_midrow_changes();
        test_full_width_row();
        test_max_scale_row();
        test_max_rows_frame();
        test_random_frames();
        settle();

        $display("sent %0d items, checked %0d results, %0d of them output pixels",
                 items_sent, results_checked, pixels_out);
        $display("%0d frames ended across default, zero, largest, mid-row and random geometry",
                 frames_done);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
